@@ hw/rtl/rnm_pkg.sv @@
// Shared types and constants for the register renamer and active list.
// Used by the top level and the testbench; depends on nothing.
package rnm_pkg;

  localparam int LogicalRegs  = 32;
  localparam int PhysicalRegs = 128;
  localparam int ListDepth    = 64;
  localparam int FreeSize     = PhysicalRegs - LogicalRegs;

  localparam int LW = $clog2(LogicalRegs);
  localparam int PW = $clog2(PhysicalRegs);
  localparam int EW = $clog2(ListDepth);
  localparam int FW = $clog2(FreeSize);
  localparam int CW = $clog2(FreeSize + 1);
  localparam int NW = $clog2(ListDepth + 1);

  // Active list entry: destination flag, logical, physical, status and type flags.
  localparam int InfoW = 1 + LW + PW + 10;

  typedef enum logic [3:0] {
    K_LOOKUP   = 4'd0,
    K_ALLOC    = 4'd1,
    K_DISPATCH = 4'd2,
    K_READ     = 4'd3,
    K_WRITE    = 4'd4,
    K_SET_RDY  = 4'd5,
    K_CLR_RDY  = 4'd6,
    K_MARK     = 4'd7,
    K_QUERY    = 4'd8,
    K_COMMIT   = 4'd9,
    K_SQUASH   = 4'd10
  } kind_t;

  localparam logic [2:0] MarkLast = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HEAD,
    ST_OUT
  } state_t;

endpackage

@@ hw/rtl/register_renamer_active_list_unit.sv @@
// Top level of the register renamer with free list and active list.
// Depends on rnm_pkg and rnm_ram.
//
// Usage:
// One input channel (in_valid / in_stall) carries a request with a kind
// selector; one output channel (out_valid / out_stall) returns exactly one
// result per request. A request is taken when in_valid is high and in_stall
// is low; a result is taken when out_valid is high and out_stall is low.
// Each request passes through accept and memory read, execute with write
// back, head entry read, then the result register. The block works on one
// request at a time; in_stall is high from accept until the result has
// been taken, so no new request is taken before the last result is. The
// head entry read shares the active list RAM read port with the execute read.
// While the receiver stalls, the result and all status fields hold.
// Reset (rst, synchronous) empties the active list, fills the free list
// with the registers above the logical ones, maps each logical register to
// itself, clears all register values and marks the first registers ready.
// No clearing pass is needed.
module register_renamer_active_list_unit
  import rnm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  kind,
  input  logic [4:0]  logical_reg,
  input  logic [6:0]  physical_reg,
  input  logic        has_destination,
  input  logic [4:0]  instr_type_bits,
  input  logic [63:0] instr_pc,
  input  logic [63:0] write_value,
  input  logic [5:0]  entry_index,
  input  logic [2:0]  mark_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  result_phys,
  output logic [5:0]  result_entry,
  output logic [63:0] read_data,
  output logic        ready_flag,
  output logic        exception_flag,
  output logic        head_present,
  output logic [9:0]  head_flags,
  output logic [63:0] head_pc,
  output logic [6:0]  free_regs,
  output logic [6:0]  free_entries,
  output logic        refused
);

  state_t state, state_next;

  // Latched request.
  kind_t       q_kind;
  logic [LW-1:0] q_lreg;
  logic [PW-1:0] q_preg;
  logic        q_dst;
  logic [4:0]  q_tbits;
  logic [63:0] q_pc;
  logic [63:0] q_wval;
  logic [EW-1:0] q_eidx;
  logic [2:0]  q_code;

  // Maps and small state in flops.
  logic [PW-1:0] spec_map [LogicalRegs];
  logic [PW-1:0] comm_map [LogicalRegs];
  logic [PhysicalRegs-1:0] ready_bits;
  logic [PhysicalRegs-1:0] rv_valid;
  logic [FreeSize-1:0]     fr_valid;

  logic [FW-1:0] free_head, free_tail;
  logic          free_head_phase, free_tail_phase;
  logic [EW-1:0] list_head, list_tail;
  logic          list_head_phase, list_tail_phase;

  logic accept, deliver;
  logic [CW-1:0] free_cnt;
  logic [NW-1:0] list_used;

  // Memory ports.
  logic              info_we, info_re;
  logic [EW-1:0]     info_waddr, info_raddr;
  logic [InfoW-1:0]  info_wdata, info_rdata;
  logic              pc_re;
  logic [63:0]       pc_rdata;
  logic              rv_we;
  logic [63:0]       rv_rdata;
  logic              fr_we;
  logic [PW-1:0]     fr_wdata, fr_rdata;
  logic [FW-1:0]     fr_raddr_q;
  logic              rv_valid_q;
  logic              fr_valid_q;

  // Execute stage decisions.
  logic [PW-1:0] fr_value;
  logic          head_dst;
  logic [LW-1:0] head_lreg;
  logic [PW-1:0] head_preg;
  logic          do_alloc, do_dispatch, do_commit, do_free_push, do_refuse;

  assign accept  = in_valid && !in_stall;
  assign deliver = out_valid && !out_stall;

  always_comb begin
    if (free_head_phase == free_tail_phase) begin
      free_cnt = CW'(free_tail) - CW'(free_head);
    end else begin
      free_cnt = CW'(FreeSize) - CW'(free_head) + CW'(free_tail);
    end
    if (list_head_phase == list_tail_phase) begin
      list_used = NW'(list_tail) - NW'(list_head);
    end else begin
      list_used = NW'(ListDepth) - NW'(list_head) + NW'(list_tail);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_HEAD;
      ST_HEAD: state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: in_stall  = 1'b0;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_kind  <= kind_t'(kind);
      q_lreg  <= logical_reg;
      q_preg  <= physical_reg;
      q_dst   <= has_destination;
      q_tbits <= instr_type_bits;
      q_pc    <= instr_pc;
      q_wval  <= write_value;
      q_eidx  <= entry_index;
      q_code  <= mark_code;
      fr_raddr_q <= free_head;
      rv_valid_q <= rv_valid[physical_reg];
      fr_valid_q <= fr_valid[free_head];
    end
  end

  // Read decisions.
  assign info_re    = accept || (state == ST_HEAD);
  assign info_raddr = (state == ST_HEAD) ? list_head :
                      (kind_t'(kind) == K_COMMIT) ? list_head : entry_index;
  assign pc_re      = (state == ST_HEAD);

  // An entry of the free ring that was never written reads as its reset value, LogicalRegs plus its index.
  assign fr_value  = fr_valid_q ? fr_rdata : PW'(LogicalRegs + int'(fr_raddr_q));
  assign head_dst  = info_rdata[InfoW-1];
  assign head_lreg = info_rdata[InfoW-2 -: LW];
  assign head_preg = info_rdata[10 +: PW];

  always_comb begin
    do_alloc     = 1'b0;
    do_dispatch  = 1'b0;
    do_commit    = 1'b0;
    do_free_push = 1'b0;
    do_refuse    = 1'b0;
    info_we      = 1'b0;
    info_waddr   = q_eidx;
    info_wdata   = info_rdata;
    rv_we        = 1'b0;
    fr_we        = 1'b0;
    fr_wdata     = comm_map[head_lreg];
    if (state == ST_EXEC) begin
      case (q_kind)
        K_ALLOC: begin
          if (free_cnt == '0) do_refuse = 1'b1;
          else                do_alloc  = 1'b1;
        end
        K_DISPATCH: begin
          if (list_used >= NW'(ListDepth)) begin
            do_refuse = 1'b1;
          end else begin
            do_dispatch = 1'b1;
            info_we     = 1'b1;
            info_waddr  = list_tail;
            info_wdata  = {q_dst, q_dst ? q_lreg : LW'(0), q_preg & {PW{q_dst}},
                           q_tbits, 5'd0};
          end
        end
        K_WRITE: rv_we = 1'b1;
        K_MARK: begin
          if (q_code <= MarkLast) begin
            info_we    = 1'b1;
            info_wdata = info_rdata | InfoW'(10'd1 << q_code);
          end
        end
        K_COMMIT: begin
          if (list_used == '0) begin
            do_refuse = 1'b1;
          end else if (head_dst && free_cnt >= CW'(FreeSize)) begin
            do_refuse = 1'b1;
          end else begin
            do_commit    = 1'b1;
            do_free_push = head_dst;
            fr_we        = head_dst;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      result_phys    <= '0;
      result_entry   <= '0;
      read_data      <= '0;
      ready_flag     <= 1'b0;
      exception_flag <= 1'b0;
      refused        <= do_refuse;
      case (q_kind)
        K_LOOKUP: result_phys <= spec_map[q_lreg];
        K_ALLOC:  if (do_alloc) result_phys <= fr_value;
        K_DISPATCH: if (do_dispatch) result_entry <= list_tail;
        K_READ: begin
          read_data  <= rv_valid_q ? rv_rdata : 64'd0;
          ready_flag <= ready_bits[q_preg];
        end
        K_QUERY: exception_flag <= info_rdata[1];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LogicalRegs; i++) begin
        spec_map[i] <= PW'(i);
        comm_map[i] <= PW'(i);
      end
      for (int i = 0; i < PhysicalRegs; i++) begin
        ready_bits[i] <= (i < LogicalRegs);
      end
      rv_valid        <= '0;
      fr_valid        <= '0;
      free_head       <= '0;
      free_head_phase <= 1'b0;
      free_tail       <= '0;
      free_tail_phase <= 1'b1;
      list_head       <= '0;
      list_head_phase <= 1'b0;
      list_tail       <= '0;
      list_tail_phase <= 1'b0;
    end else if (state == ST_EXEC) begin
      if (do_alloc) begin
        spec_map[q_lreg] <= fr_value;
        if (free_head == FW'(FreeSize - 1)) begin
          free_head       <= '0;
          free_head_phase <= !free_head_phase;
        end else begin
          free_head <= free_head + 1'b1;
        end
      end
      if (do_dispatch) begin
        if (list_tail == EW'(ListDepth - 1)) begin
          list_tail       <= '0;
          list_tail_phase <= !list_tail_phase;
        end else begin
          list_tail <= list_tail + 1'b1;
        end
      end
      if (rv_we) rv_valid[q_preg] <= 1'b1;
      if (q_kind == K_SET_RDY) ready_bits[q_preg] <= 1'b1;
      if (q_kind == K_CLR_RDY) ready_bits[q_preg] <= 1'b0;
      if (do_free_push) begin
        fr_valid[free_tail]  <= 1'b1;
        comm_map[head_lreg]  <= head_preg;
        if (free_tail == FW'(FreeSize - 1)) begin
          free_tail       <= '0;
          free_tail_phase <= !free_tail_phase;
        end else begin
          free_tail <= free_tail + 1'b1;
        end
      end
      if (do_commit) begin
        if (list_head == EW'(ListDepth - 1)) begin
          list_head       <= '0;
          list_head_phase <= !list_head_phase;
        end else begin
          list_head <= list_head + 1'b1;
        end
      end
      if (q_kind == K_SQUASH) begin
        for (int i = 0; i < LogicalRegs; i++) begin
          spec_map[i] <= comm_map[i];
        end
        list_tail       <= list_head;
        list_tail_phase <= list_head_phase;
        free_head       <= free_tail;
        free_head_phase <= !free_tail_phase;
      end
    end
  end

  rnm_ram #(.WIDTH(InfoW), .DEPTH(ListDepth)) u_info_ram (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .re(info_re), .raddr(info_raddr), .rdata(info_rdata)
  );

  rnm_ram #(.WIDTH(64), .DEPTH(ListDepth)) u_pc_ram (
    .clk(clk), .we(do_dispatch), .waddr(list_tail), .wdata(q_pc),
    .re(pc_re), .raddr(list_head), .rdata(pc_rdata)
  );

  rnm_ram #(.WIDTH(64), .DEPTH(PhysicalRegs)) u_value_ram (
    .clk(clk), .we(rv_we), .waddr(q_preg), .wdata(q_wval),
    .re(accept), .raddr(physical_reg), .rdata(rv_rdata)
  );

  rnm_ram #(.WIDTH(PW), .DEPTH(FreeSize)) u_free_ram (
    .clk(clk), .we(fr_we), .waddr(free_tail), .wdata(fr_wdata),
    .re(accept), .raddr(free_head), .rdata(fr_rdata)
  );

  // Status reflects the pointers after the request; the head entry was read
  // after the write back, so it is current too.
  assign head_present = (list_used != '0);
  assign head_flags   = head_present ? info_rdata[9:0] : 10'd0;
  assign head_pc      = head_present ? pc_rdata : 64'd0;
  assign free_regs    = 7'(free_cnt);
  assign free_entries = 7'(NW'(ListDepth) - list_used);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted while a result is pending");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= CW'(FreeSize))
    else $error("free list count out of range");

  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    list_used <= NW'(ListDepth))
    else $error("active list count out of range");

  a_deliver_idle: assert property (@(posedge clk) disable iff (rst)
    deliver |=> !out_valid && !in_stall)
    else $error("block not idle after a result was taken");

endmodule

@@ hw/rtl/rnm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package needed.
module rnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ dv/register_renamer_active_list_unit_test.sv @@
// Self-checking test of the register renamer and active list unit.
// Depends on rnm_pkg and the unit RTL; a scoreboard class predicts every result.
module register_renamer_active_list_unit_test;
  import rnm_pkg::*;

  localparam logic [2:0] MarkExc  = 3'd1;

  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  lreg;
    logic [6:0]  preg;
    logic        dst;
    logic [4:0]  tbits;
    logic [63:0] pc;
    logic [63:0] wval;
    logic [5:0]  eidx;
    logic [2:0]  code;
  } rename_req_t;

  typedef struct packed {
    logic [6:0]  phys;
    logic [5:0]  entry;
    logic [63:0] data;
    logic        rdy;
    logic        exc;
    logic        hp;
    logic [9:0]  hflags;
    logic [63:0] hpc;
    logic [6:0]  fregs;
    logic [6:0]  fents;
    logic        refd;
  } rename_res_t;

  class rename_scoreboard;
    logic [6:0]  spec_map[LogicalRegs];
    logic [6:0]  arch_map[LogicalRegs];
    logic [6:0]  free_ring[FreeSize];
    int          fh, ft, lh, lt;
    bit          fhp, ftp, lhp, ltp;
    bit          e_dst[ListDepth];
    logic [4:0]  e_log[ListDepth];
    logic [6:0]  e_phys[ListDepth];
    logic [9:0]  e_flags[ListDepth];
    logic [63:0] e_pc[ListDepth];
    bit          e_written[ListDepth];
    logic [63:0] values[PhysicalRegs];
    bit          ready[PhysicalRegs];
    rename_res_t pending_q[$];
    int          mismatches, checked, refusals, full_hits, empty_hits;

    function new();
      for (int i = 0; i < LogicalRegs; i++) begin
        spec_map[i] = 7'(i);
        arch_map[i] = 7'(i);
      end
      for (int i = 0; i < FreeSize; i++) free_ring[i] = 7'(LogicalRegs + i);
      fh = 0; ft = 0; fhp = 0; ftp = 1;
      lh = 0; lt = 0; lhp = 0; ltp = 0;
      for (int i = 0; i < PhysicalRegs; i++) begin
        values[i] = '0;
        ready[i] = (i < LogicalRegs);
      end
    endfunction

    function int free_cnt();
      return (fhp == ftp) ? ft - fh : FreeSize - fh + ft;
    endfunction

    function int list_used();
      return (lhp == ltp) ? lt - lh : ListDepth - lh + lt;
    endfunction

    // Applies one accepted request to the predicted state and queues its result.
    function void note_request(rename_req_t r);
      rename_res_t e;
      e = '0;
      case (r.kind)
        K_LOOKUP: e.phys = spec_map[r.lreg];
        K_ALLOC: begin
          if (free_cnt() == 0) begin
            e.refd = 1;
          end else begin
            e.phys = free_ring[fh];
            spec_map[r.lreg] = free_ring[fh];
            fh++;
            if (fh >= FreeSize) begin fh = 0; fhp = ~fhp; end
          end
        end
        K_DISPATCH: begin
          if (list_used() >= ListDepth) begin
            e.refd = 1;
          end else begin
            e_dst[lt] = r.dst;
            e_log[lt] = r.dst ? r.lreg : '0;
            e_phys[lt] = r.dst ? r.preg : '0;
            e_flags[lt] = {r.tbits, 5'b0};
            e_pc[lt] = r.pc;
            e_written[lt] = 1;
            e.entry = 6'(lt);
            lt++;
            if (lt >= ListDepth) begin lt = 0; ltp = ~ltp; end
          end
        end
        K_READ: begin
          e.data = values[r.preg];
          e.rdy = ready[r.preg];
        end
        K_WRITE:   values[r.preg] = r.wval;
        K_SET_RDY: ready[r.preg] = 1;
        K_CLR_RDY: ready[r.preg] = 0;
        K_MARK:    if (r.code <= MarkLast) e_flags[r.eidx][r.code] = 1'b1;
        K_QUERY:   e.exc = e_flags[r.eidx][MarkExc];
        K_COMMIT: begin
          if (list_used() == 0) begin
            e.refd = 1;
          end else if (e_dst[lh] && free_cnt() >= FreeSize) begin
            e.refd = 1;
          end else begin
            if (e_dst[lh]) begin
              free_ring[ft] = arch_map[e_log[lh]];
              ft++;
              if (ft >= FreeSize) begin ft = 0; ftp = ~ftp; end
              arch_map[e_log[lh]] = e_phys[lh];
            end
            lh++;
            if (lh >= ListDepth) begin lh = 0; lhp = ~lhp; end
          end
        end
        K_SQUASH: begin
          spec_map = arch_map;
          lt = lh; ltp = lhp;
          fh = ft; fhp = ~ftp;
        end
        default: ;
      endcase
      if (list_used() != 0) begin
        e.hp = 1;
        e.hflags = e_flags[lh];
        e.hpc = e_pc[lh];
      end
      e.fregs = 7'(free_cnt());
      e.fents = 7'(ListDepth - list_used());
      if (e.refd) refusals++;
      if (list_used() == ListDepth) full_hits++;
      if (free_cnt() == 0) empty_hits++;
      pending_q.push_back(e);
    endfunction

    function void check_result(rename_res_t got);
      rename_res_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on result %0d", checked);
          $display("  expected %p", e);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, in_stall, out_valid, out_stall = 1;
  logic [3:0]  kind = '0;
  logic [4:0]  logical_reg = '0;
  logic [6:0]  physical_reg = '0;
  logic        has_destination = 0;
  logic [4:0]  instr_type_bits = '0;
  logic [63:0] instr_pc = '0, write_value = '0;
  logic [5:0]  entry_index = '0;
  logic [2:0]  mark_code = '0;
  logic [6:0]  result_phys, free_regs, free_entries;
  logic [5:0]  result_entry;
  logic [63:0] read_data, head_pc;
  logic        ready_flag, exception_flag, head_present, refused;
  logic [9:0]  head_flags;

  rename_scoreboard sb = new();
  int hold_cycles = 0;
  int hold_req = 0;
  int hold_seen = 0;
  bit quiet_out = 0;

  register_renamer_active_list_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_request({kind, logical_reg, physical_reg, has_destination, instr_type_bits,
                       instr_pc, write_value, entry_index, mark_code});
    if (!rst && out_valid && !out_stall)
      sb.check_result({result_phys, result_entry, read_data, ready_flag, exception_flag,
                       head_present, head_flags, head_pc, free_regs, free_entries, refused});
  end

  // Receiver: random stalls, long holds on request, and calm stretches.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_cycles <= 300;
      out_stall <= 1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else if (quiet_out) begin
      out_stall <= 0;
    end else if ($urandom_range(99) < 4) begin
      hold_cycles <= $urandom_range(40, 10);
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < 30);
    end
  end

  task automatic send_request(rename_req_t r);
    kind <= r.kind; logical_reg <= r.lreg; physical_reg <= r.preg;
    has_destination <= r.dst; instr_type_bits <= r.tbits; instr_pc <= r.pc;
    write_value <= r.wval; entry_index <= r.eidx; mark_code <= r.code;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_sender(bit calm);
    int n;
    n = calm ? 0 : ($urandom_range(99) < 5 ? $urandom_range(40, 10) : $urandom_range(2));
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  function automatic rename_req_t random_fields(logic [3:0] k);
    rename_req_t r;
    int n;
    r.kind = k;
    r.lreg = 5'($urandom);
    r.preg = 7'($urandom);
    r.dst = 1'($urandom);
    r.tbits = 5'($urandom);
    r.pc = {$urandom, $urandom};
    r.wval = {$urandom, $urandom};
    r.code = 3'($urandom_range(MarkLast));
    if ($urandom_range(9) == 0) r.code = 3'($urandom_range(7, MarkLast + 1));
    // Only entries that a dispatch has filled are marked or queried.
    r.eidx = '0;
    if (k == K_MARK || k == K_QUERY) begin
      n = 0;
      for (int i = 0; i < ListDepth; i++) n += sb.e_written[i];
      if (n == 0) begin
        r.kind = K_LOOKUP;
      end else begin
        do r.eidx = 6'($urandom); while (!sb.e_written[r.eidx]);
      end
    end
    return r;
  endfunction

  task automatic send_kind(logic [3:0] k, bit calm = 0);
    send_request(random_fields(k));
    idle_sender(calm);
  endtask

  initial begin
    rename_req_t r;
    int sent, burst;
    logic [3:0] k;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: commit on empty list, commit refused on a full free list,
    // every kind, all mark codes, an unknown kind and field extremes.
    send_kind(K_COMMIT);
    r = random_fields(K_DISPATCH);
    r.dst = 1; r.lreg = '1; r.preg = '1; r.tbits = '1; r.pc = '1;
    send_request(r);
    send_kind(K_COMMIT);
    r = random_fields(K_WRITE);
    r.preg = '1; r.wval = '1;
    send_request(r);
    r.kind = K_READ;
    send_request(r);
    r.preg = '0; r.kind = K_CLR_RDY;
    send_request(r);
    r.kind = K_READ;
    send_request(r);
    r.kind = K_SET_RDY;
    send_request(r);
    send_kind(K_ALLOC);
    send_kind(K_LOOKUP);
    for (int c = 0; c < 8; c++) begin
      r = random_fields(K_MARK);
      r.code = 3'(c);
      send_request(r);
    end
    send_kind(K_QUERY);
    r = random_fields(K_SQUASH);
    r.kind = 4'(K_SQUASH) + 4'd1;
    send_request(r);
    r.kind = '1;
    send_request(r);
    send_kind(K_SQUASH);
    sent = 22;

    // Random: bursts that fill the active list or drain the free list, and
    // mixed traffic that dispatches, allocates, marks and commits.
    while (sent < 1550) begin
      case ($urandom_range(9))
        0: begin
          burst = $urandom_range(ListDepth + 6, 20);
          for (int i = 0; i < burst; i++) send_kind(K_DISPATCH, 1);
          sent += burst;
        end
        1: begin
          burst = $urandom_range(FreeSize + 4, 30);
          for (int i = 0; i < burst; i++) send_kind(K_ALLOC, 1);
          sent += burst;
        end
        2: begin
          burst = $urandom_range(30, 5);
          for (int i = 0; i < burst; i++) send_kind(K_COMMIT);
          sent += burst;
        end
        3: begin
          // Long receiver hold while requests keep coming.
          hold_req++;
          for (int i = 0; i < 6; i++) send_kind(K_DISPATCH, 1);
          sent += 6;
        end
        4: begin
          wait_drained();
          send_kind($urandom_range(99) < 50 ? K_SQUASH : K_LOOKUP);
          sent++;
        end
        5: begin
          quiet_out = 1;
          for (int i = 0; i < 20; i++) begin
            k = 4'($urandom_range(K_SQUASH - 1));
            send_kind(k, 1);
          end
          quiet_out = 0;
          sent += 20;
        end
        default: begin
          k = 4'($urandom_range(99) < 3 ? $urandom_range(15, K_SQUASH + 1)
                                        : $urandom_range(K_SQUASH));
          send_kind(k);
          sent++;
        end
      endcase
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests with %0d refusals; list full %0d times, free list empty %0d.",
             sent, sb.refusals, sb.full_hits, sb.empty_hits);
    $display("Results checked: %0d, mismatches: %0d.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("register_renamer_active_list_unit_test: done, clean");
    else
      $display("register_renamer_active_list_unit_test: done, errors");
    $finish;
  end

  initial begin
    #5000000;
    $display("register_renamer_active_list_unit_test: done, errors");
    $finish;
  end

endmodule
